### src/cborie_pkg.sv
// Package for the CBOR integer encoder: field widths, head byte codes and
// the encoder result structure. Depends on nothing; used by all modules.

package cborie_pkg;

    localparam int VALUE_W      = 64;
    localparam int LIMIT_W      = 8;
    localparam int BYTE_W       = 8;
    localparam int FRAME_BYTES  = 9;
    localparam int FRAME_W      = FRAME_BYTES * BYTE_W;
    localparam int CNT_W        = 4;
    localparam int IN_DATA_W    = VALUE_W + LIMIT_W;

    localparam logic [4:0] HEAD_NUM_MAX = 5'd23;
    localparam logic [4:0] INFO_ONE     = 5'd24;
    localparam logic [4:0] INFO_TWO     = 5'd25;
    localparam logic [4:0] INFO_FOUR    = 5'd26;
    localparam logic [4:0] INFO_EIGHT   = 5'd27;

    localparam logic [2:0] MAJOR_UNSIGNED = 3'd0;
    localparam logic [2:0] MAJOR_NEGATIVE = 3'd1;

    localparam logic [CNT_W-1:0] LEN_ONE   = 4'd1;
    localparam logic [CNT_W-1:0] LEN_TWO   = 4'd2;
    localparam logic [CNT_W-1:0] LEN_THREE = 4'd3;
    localparam logic [CNT_W-1:0] LEN_FIVE  = 4'd5;
    localparam logic [CNT_W-1:0] LEN_NINE  = 4'd9;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [CNT_W-1:0]   total;
        logic               fail;
    } enc_t;

endpackage

### src/cbor_integer_encoder.sv
// Top level of the CBOR integer encoder: input register, encoder and byte
// serialiser on the result side. Depends on cborie_pkg and cborie_encode.
//
// Usage: an input transaction carries the value and space limit in
// s_axis_tdata and the signed flag in s_axis_tuser. Each input yields the
// shortest CBOR head encoding, one byte per output transaction on
// m_axis_tdata, head byte first, with m_axis_tlast on the final byte.
// If the encoding does not fit the space limit, a single transaction with
// data 0, m_axis_tuser (fail) and m_axis_tlast high is sent instead.
// The input is held in the input register and then loaded into the byte
// buffer, from which the first byte is offered; a busy output delays the load.
// Throughput: one output byte per cycle while m_axis_tready is high; items
// are 1, 2, 3, 5 or 9 bytes long, and this serialiser sets the rate.
// The input register accepts the next item while the current one is still
// being sent, and hands it over in the cycle its last byte is taken.
// Reset empties both registers; nothing is offered until a new input.
// While the receiver holds m_axis_tready low, the offered byte holds and
// the input side fills at most one further item before stalling.

module cbor_integer_encoder
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: value [63:0], space_limit [71:64]
    input  logic [cborie_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: cmd (1 means signed)
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: out_byte [7:0]
    output logic [cborie_pkg::BYTE_W-1:0]    m_axis_tdata,
    output logic                             m_axis_tlast,
    // tuser: fail
    output logic                             m_axis_tuser
);
    import cborie_pkg::*;

    logic                  in_valid_reg;
    logic                  cmd_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    logic                  out_valid_reg;
    logic [FRAME_W-1:0]    buf_reg;
    logic [FRAME_W-1:0]    buf_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  fail_reg;

    enc_t                  enc;
    logic                  out_take;
    logic                  out_done;
    logic                  load;
    logic                  in_take;

    cborie_encode u_encode
    (
        .cmd         (cmd_reg),
        .value       (value_reg),
        .space_limit (limit_reg),
        .enc         (enc)
    );

    assign out_take      = out_valid_reg && m_axis_tready;
    assign out_done      = out_take && (cnt_reg == LEN_ONE);
    assign load          = in_valid_reg && (!out_valid_reg || out_done);
    assign s_axis_tready = !in_valid_reg || load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg   <= s_axis_tuser;
            value_reg <= s_axis_tdata[VALUE_W-1:0];
            limit_reg <= s_axis_tdata[IN_DATA_W-1:VALUE_W];
        end
    end

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            buf_next = enc.fail ? '0 : enc.frame;
            cnt_next = enc.fail ? LEN_ONE : enc.total;
        end
        else if (out_take)
        begin
            buf_next = {buf_reg[FRAME_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            cnt_next = cnt_reg - LEN_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            fail_reg      <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
                fail_reg      <= enc.fail;
            end
            else if (out_done)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = buf_reg[FRAME_W-1:FRAME_W-BYTE_W];
    assign m_axis_tlast  = (cnt_reg == LEN_ONE);
    assign m_axis_tuser  = fail_reg;

    a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("failed item is not a single zero byte");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((cnt_reg != '0) && (cnt_reg <= LEN_NINE)))
        else $error("byte count out of range while output is valid");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(cnt_reg)))
        else $error("byte count moved while the receiver stalled");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_valid_reg) |-> out_done)
        else $error("new item loaded over an unfinished one");

endmodule

### src/cborie_encode.sv
// Combinational CBOR integer head encoder: builds the byte frame, its length
// and the fail flag for one item. Depends on cborie_pkg.

module cborie_encode
(
    input  logic                           cmd,
    input  logic [cborie_pkg::VALUE_W-1:0] value,
    input  logic [cborie_pkg::LIMIT_W-1:0] space_limit,
    output cborie_pkg::enc_t               enc
);
    import cborie_pkg::*;

    logic                negative;
    logic [VALUE_W-1:0]  mag;
    logic [2:0]          major;
    logic [4:0]          info;
    logic [VALUE_W-1:0]  arg_aligned;
    logic [CNT_W-1:0]    total;

    assign negative = cmd && value[VALUE_W-1];
    assign mag      = negative ? ~value : value;
    assign major    = negative ? MAJOR_NEGATIVE : MAJOR_UNSIGNED;

    always_comb
    begin
        if (mag <= {{(VALUE_W-5){1'b0}}, HEAD_NUM_MAX})
        begin
            info        = mag[4:0];
            total       = LEN_ONE;
            arg_aligned = '0;
        end
        else if (mag[VALUE_W-1:8] == '0)
        begin
            info        = INFO_ONE;
            total       = LEN_TWO;
            arg_aligned = {mag[7:0], 56'd0};
        end
        else if (mag[VALUE_W-1:16] == '0)
        begin
            info        = INFO_TWO;
            total       = LEN_THREE;
            arg_aligned = {mag[15:0], 48'd0};
        end
        else if (mag[VALUE_W-1:32] == '0)
        begin
            info        = INFO_FOUR;
            total       = LEN_FIVE;
            arg_aligned = {mag[31:0], 32'd0};
        end
        else
        begin
            info        = INFO_EIGHT;
            total       = LEN_NINE;
            arg_aligned = mag;
        end
    end

    assign enc.frame = {major, info, arg_aligned};
    assign enc.total = total;
    assign enc.fail  = (space_limit == '0) ||
                       (space_limit < {{(LIMIT_W-CNT_W){1'b0}}, total});

endmodule
